FILE: hw/rtl/far_pkg.sv
// Shared widths, operation codes and handshake structs for the fraction
// arithmetic block. No dependencies; used by every module under hw/rtl.
package far_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int PROD_W        = 2 * OPERAND_WIDTH;
   localparam int RAW_W         = PROD_W + 1;
   localparam int MAG_W         = PROD_W;
   localparam int RES_W         = 33;
   localparam int SHIFT_W       = $clog2(MAG_W);

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_SUB = 2'd1;
   localparam logic [1:0] FUNC_MUL = 2'd2;
   localparam logic [1:0] FUNC_DIV = 2'd3;

   localparam logic signed [RES_W-1:0] RES_ONE = RES_W'(1);

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] a;
      logic [MAG_W-1:0] b;
   } gcd_req_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] g;
   } gcd_rsp_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] divisor;
      logic [MAG_W-1:0] num_mag;
      logic [MAG_W-1:0] den_mag;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] q_num;
      logic [MAG_W-1:0] q_den;
   } div_rsp_type;

endpackage

FILE: hw/rtl/far_gcd.sv
// Binary greatest common divisor of two nonzero magnitudes, one shift or one
// compare-and-subtract per cycle. Depends on far_pkg.
module far_gcd (
   input  logic              clock,
   input  logic              reset,
   input  far_pkg::gcd_req_type gcd_req,
   output far_pkg::gcd_rsp_type gcd_rsp
);
   import far_pkg::*;

   typedef enum logic [3:0] {
      G_IDLE   = 4'b0001,
      G_COMMON = 4'b0010,
      G_STRIP  = 4'b0100,
      G_LOOP   = 4'b1000
   } gcd_state_type;

   gcd_state_type        state_ff, state_in;
   logic [MAG_W-1:0]     a_ff, a_in, b_ff, b_in, g_ff, g_in;
   logic [SHIFT_W-1:0]   k_ff, k_in;
   logic                 done_ff, done_in;

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      g_in     = g_ff;
      done_in  = 1'b0;
      case (state_ff)
         G_IDLE: begin
            if (gcd_req.start) begin
               a_in     = gcd_req.a;
               b_in     = gcd_req.b;
               k_in     = '0;
               state_in = G_COMMON;
            end
         end
         G_COMMON: begin
            // Pull out the power of two shared by both values.
            if (!(a_ff[0] | b_ff[0])) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + SHIFT_W'(1);
            end else begin
               state_in = G_STRIP;
            end
         end
         G_STRIP: begin
            if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else begin
               state_in = G_LOOP;
            end
         end
         G_LOOP: begin
            // a stays odd; b is made odd, then the smaller is subtracted.
            if (b_ff == '0) begin
               g_in     = a_ff << k_ff;
               done_in  = 1'b1;
               state_in = G_IDLE;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff > b_ff) begin
               a_in = b_ff;
               b_in = a_ff - b_ff;
            end else begin
               b_in = b_ff - a_ff;
            end
         end
         default: begin
            state_in = G_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end

   assign gcd_rsp.done = done_ff;
   assign gcd_rsp.g    = g_ff;

endmodule

FILE: hw/rtl/far_div.sv
// Restoring divider that divides numerator and denominator magnitudes by the
// same divisor, one quotient bit per cycle in each lane. Depends on far_pkg.
module far_div (
   input  logic              clock,
   input  logic              reset,
   input  far_pkg::div_req_type div_req,
   output far_pkg::div_rsp_type div_rsp
);
   import far_pkg::*;

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [SHIFT_W-1:0]   cnt_ff, cnt_in;
   logic [MAG_W-1:0]     divisor_ff, divisor_in;
   logic [MAG_W-1:0]     qn_ff, qn_in, qd_ff, qd_in;
   logic [MAG_W-1:0]     rn_ff, rn_in, rd_ff, rd_in;
   logic [2*MAG_W-1:0]   step_n, step_d;

   // One restoring step: returns the new remainder and the shifted quotient.
   function automatic logic [2*MAG_W-1:0] div_step(input logic [MAG_W-1:0] rem,
                                                   input logic [MAG_W-1:0] quo,
                                                   input logic [MAG_W-1:0] dvs);
      logic [MAG_W:0] shifted;
      logic [MAG_W:0] trial;
      shifted = {rem, quo[MAG_W-1]};
      trial   = shifted - {1'b0, dvs};
      if (trial[MAG_W]) begin
         div_step = {shifted[MAG_W-1:0], quo[MAG_W-2:0], 1'b0};
      end else begin
         div_step = {trial[MAG_W-1:0], quo[MAG_W-2:0], 1'b1};
      end
   endfunction

   assign step_n = div_step(rn_ff, qn_ff, divisor_ff);
   assign step_d = div_step(rd_ff, qd_ff, divisor_ff);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      divisor_in = divisor_ff;
      qn_in      = qn_ff;
      qd_in      = qd_ff;
      rn_in      = rn_ff;
      rd_in      = rd_ff;
      if (!busy_ff) begin
         if (div_req.start) begin
            busy_in    = 1'b1;
            cnt_in     = '0;
            divisor_in = div_req.divisor;
            qn_in      = div_req.num_mag;
            qd_in      = div_req.den_mag;
            rn_in      = '0;
            rd_in      = '0;
         end
      end else begin
         {rn_in, qn_in} = step_n;
         {rd_in, qd_in} = step_d;
         cnt_in         = cnt_ff + SHIFT_W'(1);
         if (cnt_ff == SHIFT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      divisor_ff <= divisor_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
   end

   assign div_rsp.done  = done_ff;
   assign div_rsp.q_num = qn_ff;
   assign div_rsp.q_den = qd_ff;

endmodule

FILE: hw/rtl/fraction_arithmetic_reduce.sv
// Fraction add/subtract/multiply/divide with reduction by the gcd.
// One request at a time: three products on the shared multiplier, then S_SUM and
// S_CHK form and test the raw values, then the binary gcd loop (its length set by
// the operand bit patterns) and the restoring divider; a zero raw value or a
// divide by zero skips both. Synchronous reset returns the sequencer to idle.
module fraction_arithmetic_reduce (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic [1:0]                                   req_func,
   input  logic signed [far_pkg::OPERAND_WIDTH-1:0]     req_a_num,
   input  logic signed [far_pkg::OPERAND_WIDTH-1:0]     req_a_den,
   input  logic signed [far_pkg::OPERAND_WIDTH-1:0]     req_b_num,
   input  logic signed [far_pkg::OPERAND_WIDTH-1:0]     req_b_den,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic signed [far_pkg::RES_W-1:0]             rsp_res_num,
   output logic signed [far_pkg::RES_W-1:0]             rsp_res_den,
   output logic                                         rsp_div_zero
);
   import far_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MUL  = 7'b0000010,
      S_SUM  = 7'b0000100,
      S_CHK  = 7'b0001000,
      S_GCD  = 7'b0010000,
      S_DIV  = 7'b0100000,
      S_OUT  = 7'b1000000
   } seq_state_type;

   seq_state_type                     state_ff, state_in;
   logic [1:0]                        mul_cnt_ff, mul_cnt_in;
   logic [1:0]                        func_ff;
   logic signed [OPERAND_WIDTH-1:0]   an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [OPERAND_WIDTH-1:0]   op_x, op_y;
   logic signed [PROD_W-1:0]          prod;
   logic signed [PROD_W-1:0]          p0_ff, p1_ff, pd_ff;
   logic signed [RAW_W-1:0]           n_ff, n_in, d_ff, d_in;
   logic [MAG_W-1:0]                  n_mag, d_mag;
   logic signed [RAW_W-1:0]           qn_s, qd_s;
   logic signed [RES_W-1:0]           res_num_ff, res_num_in, res_den_ff, res_den_in;
   logic                              div_zero_ff, div_zero_in;
   logic                              req_fire;
   gcd_req_type                       gcd_req;
   gcd_rsp_type                       gcd_rsp;
   div_req_type                       div_req;
   div_rsp_type                       div_rsp;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign req_fire  = req_valid && req_ready;

   // Operand pairs for the three products, chosen per operation.
   always_comb begin
      op_x = ad_ff;
      op_y = bd_ff;
      case (mul_cnt_ff)
         2'd0: begin
            case (func_ff)
               FUNC_ADD: begin op_x = ad_ff; op_y = bn_ff; end
               FUNC_MUL: begin op_x = an_ff; op_y = bn_ff; end
               default:  begin op_x = an_ff; op_y = bd_ff; end
            endcase
         end
         2'd1: begin
            if (func_ff == FUNC_ADD) begin
               op_x = an_ff;
               op_y = bd_ff;
            end else begin
               op_x = ad_ff;
               op_y = bn_ff;
            end
         end
         default: begin
            if (func_ff == FUNC_DIV) begin
               op_x = ad_ff;
               op_y = bn_ff;
            end else begin
               op_x = ad_ff;
               op_y = bd_ff;
            end
         end
      endcase
   end

   assign prod = op_x * op_y;

   always_comb begin
      case (func_ff)
         FUNC_ADD: n_in = RAW_W'(p0_ff) + RAW_W'(p1_ff);
         FUNC_SUB: n_in = RAW_W'(p0_ff) - RAW_W'(p1_ff);
         default:  n_in = RAW_W'(p0_ff);
      endcase
      d_in = RAW_W'(pd_ff);
   end

   assign n_mag = n_ff[RAW_W-1] ? MAG_W'(-n_ff) : MAG_W'(n_ff);
   assign d_mag = d_ff[RAW_W-1] ? MAG_W'(-d_ff) : MAG_W'(d_ff);

   assign gcd_req.start = (state_ff == S_CHK) && !(func_ff == FUNC_DIV && d_ff == '0)
                          && (n_ff != '0) && (d_ff != '0);
   assign gcd_req.a     = n_mag;
   assign gcd_req.b     = d_mag;

   assign div_req.start   = (state_ff == S_GCD) && gcd_rsp.done;
   assign div_req.divisor = gcd_rsp.g;
   assign div_req.num_mag = n_mag;
   assign div_req.den_mag = d_mag;

   assign qn_s = signed'({1'b0, div_rsp.q_num});
   assign qd_s = signed'({1'b0, div_rsp.q_den});

   always_comb begin
      state_in    = state_ff;
      mul_cnt_in  = mul_cnt_ff;
      res_num_in  = res_num_ff;
      res_den_in  = res_den_ff;
      div_zero_in = div_zero_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mul_cnt_in = '0;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            mul_cnt_in = mul_cnt_ff + 2'd1;
            if (mul_cnt_ff == 2'd2) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            div_zero_in = 1'b0;
            if (func_ff == FUNC_DIV && d_ff == '0) begin
               res_num_in  = '0;
               res_den_in  = RES_ONE;
               div_zero_in = 1'b1;
               state_in    = S_OUT;
            end else if (n_ff == '0 || d_ff == '0) begin
               // A zero raw value skips the gcd; a zero numerator gets a unit denominator.
               res_num_in = RES_W'(n_ff);
               res_den_in = (n_ff == '0) ? RES_ONE : RES_W'(d_ff);
               state_in   = S_OUT;
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (gcd_rsp.done) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               res_num_in = RES_W'(n_ff[RAW_W-1] ? -qn_s : qn_s);
               res_den_in = RES_W'(d_ff[RAW_W-1] ? -qd_s : qd_s);
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_cnt_ff  <= mul_cnt_in;
      res_num_ff  <= res_num_in;
      res_den_ff  <= res_den_in;
      div_zero_ff <= div_zero_in;
      if (req_fire) begin
         func_ff <= req_func;
         an_ff   <= req_a_num;
         ad_ff   <= req_a_den;
         bn_ff   <= req_b_num;
         bd_ff   <= req_b_den;
      end
      if (state_ff == S_MUL) begin
         case (mul_cnt_ff)
            2'd0:    p0_ff <= prod;
            2'd1:    p1_ff <= prod;
            default: pd_ff <= prod;
         endcase
      end
      if (state_ff == S_SUM) begin
         n_ff <= n_in;
         d_ff <= d_in;
      end
   end

   far_gcd u_gcd (
      .clock   (clock),
      .reset   (reset),
      .gcd_req (gcd_req),
      .gcd_rsp (gcd_rsp)
   );

   far_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_res_num  = res_num_ff;
   assign rsp_res_den  = res_den_ff;
   assign rsp_div_zero = div_zero_ff;

   // A zero numerator always comes with a unit denominator.
   a_zero_num_unit_den : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_res_num == '0) |-> (rsp_res_den == RES_ONE))
      else $error("zero numerator without unit denominator");

   a_div_zero_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero) |-> (rsp_res_num == '0 && func_ff == FUNC_DIV))
      else $error("divide-by-zero flag with a nonzero result");

   a_one_request : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("second request taken while one is in flight");

   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready for a request while a result is pending");

endmodule

FILE: tb/fraction_arithmetic_reduce_checker.sv
`timescale 1ns / 100ps
// Request/result monitor for fraction_arithmetic_reduce: predicts each reduced
// fraction from the accepted request and compares it with the returned result.
// Depends on far_pkg for operand widths, result width and operation codes.
module fraction_arithmetic_reduce_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic [1:0]                               req_func,
   input  logic signed [far_pkg::OPERAND_WIDTH-1:0] req_a_num,
   input  logic signed [far_pkg::OPERAND_WIDTH-1:0] req_a_den,
   input  logic signed [far_pkg::OPERAND_WIDTH-1:0] req_b_num,
   input  logic signed [far_pkg::OPERAND_WIDTH-1:0] req_b_den,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic signed [far_pkg::RES_W-1:0]         rsp_res_num,
   input  logic signed [far_pkg::RES_W-1:0]         rsp_res_den,
   input  logic                                     rsp_div_zero,
   output int                                       error_count,
   output int                                       pending_count,
   output int                                       checked_count,
   output int                                       div_zero_count
);
   import far_pkg::*;

   typedef struct {
      logic signed [RES_W-1:0] num;
      logic signed [RES_W-1:0] den;
      logic                    div_zero;
   } reduced_fraction_type;

   reduced_fraction_type expected_fractions[$];

   function automatic longint unsigned magnitude(input longint x);
      return (x < 0) ? longint'(-x) : longint'(x);
   endfunction

   // Binary gcd; a zero on either side means no reduction at all.
   function automatic longint unsigned binary_gcd(input longint unsigned x,
                                                  input longint unsigned y);
      int unsigned      twos;
      longint unsigned  swap;
      if (x == 0 || y == 0) return 1;
      twos = 0;
      while (((x | y) & 1) == 0) begin
         x >>= 1;
         y >>= 1;
         twos++;
      end
      while ((x & 1) == 0) x >>= 1;
      while (y != 0) begin
         while ((y & 1) == 0) y >>= 1;
         if (x > y) begin
            swap = x;
            x = y;
            y = swap;
         end
         y -= x;
      end
      return x << twos;
   endfunction

   function automatic reduced_fraction_type reduce_fraction(
      input logic [1:0]                      op,
      input logic signed [OPERAND_WIDTH-1:0] a_num,
      input logic signed [OPERAND_WIDTH-1:0] a_den,
      input logic signed [OPERAND_WIDTH-1:0] b_num,
      input logic signed [OPERAND_WIDTH-1:0] b_den);
      longint               an, ad, bn, bd, n, d, g;
      reduced_fraction_type r;
      an = a_num;
      ad = a_den;
      bn = b_num;
      bd = b_den;
      case (op)
         FUNC_ADD: begin
            n = ad * bn + an * bd;
            d = ad * bd;
         end
         FUNC_SUB: begin
            n = an * bd - ad * bn;
            d = ad * bd;
         end
         FUNC_MUL: begin
            n = an * bn;
            d = ad * bd;
         end
         default: begin
            n = an * bd;
            d = ad * bn;
         end
      endcase
      if (op == FUNC_DIV && d == 0) begin
         r.num = 0;
         r.den = RES_ONE;
         r.div_zero = 1'b1;
      end else begin
         g = longint'(binary_gcd(magnitude(n), magnitude(d)));
         n = n / g;
         d = d / g;
         if (n == 0) d = 1;
         r.num = n[RES_W-1:0];
         r.den = d[RES_W-1:0];
         r.div_zero = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reduced_fraction_type want;
      int                   mismatches;
      if (reset) begin
         expected_fractions.delete();
         error_count    <= 0;
         pending_count  <= 0;
         checked_count  <= 0;
         div_zero_count <= 0;
      end else begin
         mismatches = 0;
         if (rsp_valid && rsp_ready) begin
            if (expected_fractions.size() == 0) begin
               $error("result with no request outstanding: %0d/%0d div_zero=%0b",
                      rsp_res_num, rsp_res_den, rsp_div_zero);
               mismatches++;
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_res_num !== want.num) begin
                  $error("res_num: expected %0d, got %0d", want.num, rsp_res_num);
                  mismatches++;
               end
               if (rsp_res_den !== want.den) begin
                  $error("res_den: expected %0d, got %0d", want.den, rsp_res_den);
                  mismatches++;
               end
               if (rsp_div_zero !== want.div_zero) begin
                  $error("div_zero: expected %0b, got %0b", want.div_zero, rsp_div_zero);
                  mismatches++;
               end
               checked_count <= checked_count + 1;
               if (want.div_zero) div_zero_count <= div_zero_count + 1;
            end
         end
         error_count <= error_count + mismatches;
         if (req_valid && req_ready)
            expected_fractions.push_back(reduce_fraction(req_func, req_a_num, req_a_den,
                                                         req_b_num, req_b_den));
         pending_count <= expected_fractions.size();
      end
   end

endmodule

FILE: tb/fraction_arithmetic_reduce_tb.sv
`timescale 1ns / 100ps
// Top of the fraction_arithmetic_reduce testbench: clock, reset, request and
// result-side stimulus, and the verdict. Depends on far_pkg and the checker module.
module fraction_arithmetic_reduce_tb;
   import far_pkg::*;

   localparam int RANDOM_REQUESTS = 1850;
   localparam logic signed [OPERAND_WIDTH-1:0] OP_MAX = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
   localparam logic signed [OPERAND_WIDTH-1:0] OP_MIN = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
   localparam logic signed [OPERAND_WIDTH-1:0] OP_ONE = 1;
   localparam logic signed [OPERAND_WIDTH-1:0] OP_NEG = -1;
   localparam logic signed [OPERAND_WIDTH-1:0] OP_ZERO = 0;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic [1:0]                      req_func;
   logic signed [OPERAND_WIDTH-1:0] req_a_num;
   logic signed [OPERAND_WIDTH-1:0] req_a_den;
   logic signed [OPERAND_WIDTH-1:0] req_b_num;
   logic signed [OPERAND_WIDTH-1:0] req_b_den;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic signed [RES_W-1:0]         rsp_res_num;
   logic signed [RES_W-1:0]         rsp_res_den;
   logic                            rsp_div_zero;

   int   error_count;
   int   pending_count;
   int   checked_count;
   int   div_zero_count;
   int   requests_sent;
   logic quiet_stretch;

   fraction_arithmetic_reduce uut (.*);

   fraction_arithmetic_reduce_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Result side: occasional back-pressure, none during the quiet stretch.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= quiet_stretch || ($urandom_range(99) >= 6);
      end
   end

   task automatic send_request(input logic [1:0]                      op,
                               input logic signed [OPERAND_WIDTH-1:0] a_num,
                               input logic signed [OPERAND_WIDTH-1:0] a_den,
                               input logic signed [OPERAND_WIDTH-1:0] b_num,
                               input logic signed [OPERAND_WIDTH-1:0] b_den);
      @(negedge clock);
      while (!quiet_stretch && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_func  <= op;
      req_a_num <= a_num;
      req_a_den <= a_den;
      req_b_num <= b_num;
      req_b_den <= b_den;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // Stop sending and wait until every outstanding request has its result.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Mix of zeros, extremes, small values and shifted values so that the gcd
   // actually reduces, with full-width random values for the rest.
   function automatic logic signed [OPERAND_WIDTH-1:0] pick_operand();
      case ($urandom_range(9))
         0: return OP_ZERO;
         1: begin
            case ($urandom_range(3))
               0: return OP_MAX;
               1: return OP_MIN;
               2: return OP_ONE;
               default: return OP_NEG;
            endcase
         end
         2, 3, 4, 5: return OPERAND_WIDTH'($signed($urandom_range(40)) - 20);
         6: return OPERAND_WIDTH'(($signed($urandom_range(14)) - 7) << $urandom_range(8));
         default: return OPERAND_WIDTH'($urandom());
      endcase
   endfunction

   initial begin
      logic [1:0] op;
      quiet_stretch = 1'b0;
      requests_sent = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_func  <= FUNC_ADD;
      req_a_num <= OP_ZERO;
      req_a_den <= OP_ONE;
      req_b_num <= OP_ZERO;
      req_b_den <= OP_ONE;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes of every field, each operation, and the corner cases.
      send_request(FUNC_ADD, OP_ONE, 16'sd2, OP_ONE, 16'sd3);
      send_request(FUNC_SUB, 16'sd3, 16'sd4, OP_ONE, 16'sd4);
      send_request(FUNC_MUL, 16'sd6, 16'sd10, 16'sd5, 16'sd9);
      send_request(FUNC_DIV, 16'sd2, 16'sd3, 16'sd4, 16'sd9);
      send_request(FUNC_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
      send_request(FUNC_SUB, OP_MIN, OP_MAX, OP_MAX, OP_MIN);
      send_request(FUNC_MUL, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
      send_request(FUNC_MUL, OP_MAX, OP_MIN, OP_MAX, OP_ONE);
      send_request(FUNC_DIV, OP_MIN, OP_MAX, OP_MAX, OP_MIN);
      send_request(FUNC_ADD, OP_MAX, OP_MAX, OP_MAX, OP_MAX);
      // Divide by zero, from either operand.
      send_request(FUNC_DIV, 16'sd5, 16'sd7, OP_ZERO, 16'sd3);
      send_request(FUNC_DIV, 16'sd5, OP_ZERO, 16'sd2, 16'sd3);
      send_request(FUNC_DIV, OP_ZERO, OP_ZERO, OP_ZERO, OP_ZERO);
      // Zero denominator on the other operations passes through unreduced.
      send_request(FUNC_ADD, 16'sd4, OP_ZERO, 16'sd6, 16'sd2);
      send_request(FUNC_SUB, 16'sd4, 16'sd2, 16'sd6, OP_ZERO);
      send_request(FUNC_MUL, 16'sd4, OP_ZERO, 16'sd6, 16'sd8);
      // Zero numerator gives 0/1.
      send_request(FUNC_MUL, OP_ZERO, 16'sd9, 16'sd5, 16'sd7);
      send_request(FUNC_SUB, 16'sd3, 16'sd5, 16'sd3, 16'sd5);
      send_request(FUNC_DIV, OP_ZERO, 16'sd4, 16'sd3, 16'sd2);
      // Negative denominators keep their sign.
      send_request(FUNC_ADD, OP_NEG, OP_NEG, OP_ONE, 16'sd4);
      send_request(FUNC_MUL, 16'sd8, OP_NEG, 16'sd3, 16'sd12);
      send_request(FUNC_DIV, OP_NEG, 16'sd6, OP_NEG, OP_NEG);
      drain_results();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == 600) quiet_stretch = 1'b1;
         if (i == 900) quiet_stretch = 1'b0;
         if (i == 1200) drain_results();
         op = 2'($urandom_range(3));
         send_request(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
      end
      drain_results();
      repeat (200) @(posedge clock);

      $display("Sent %0d requests over add, subtract, multiply and divide with random stalls;",
               requests_sent);
      $display("%0d results compared, %0d of them divide by zero.", checked_count,
               div_zero_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/far_pkg.sv
hw/rtl/far_gcd.sv
hw/rtl/far_div.sv
hw/rtl/fraction_arithmetic_reduce.sv
tb/fraction_arithmetic_reduce_checker.sv
tb/fraction_arithmetic_reduce_tb.sv
